// ===== rtl/s2l_pkg.sv =====
// Shared constants and helpers for the sRGB-to-linear converter.
package s2l_pkg;

  localparam int COEF_NUM = 7;

  localparam longint unsigned COEF_SCALE = 64'd100000000;

  localparam longint unsigned COEF_MANT [COEF_NUM] = '{
    64'd4895813, 64'd20727534, 64'd40904131, 64'd70083753,
    64'd51648981, 64'd3244261, 64'd94529
  };

  localparam bit COEF_NEG [COEF_NUM] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

  localparam longint unsigned THRESH_NUM = 64'd4045;
  localparam longint unsigned THRESH_DEN = 64'd100000;
  localparam longint unsigned RECIP_NUM  = 64'd100;
  localparam longint unsigned RECIP_DEN  = 64'd1292;

  // Coefficient in signed fixed point with cf fraction bits, rounded half up.
  function automatic longint coef_q(input int idx, input int cf);
    longint unsigned m;
    longint unsigned q;
    m = COEF_MANT[idx];
    q = ((m << cf) + COEF_SCALE / 2) / COEF_SCALE;
    return COEF_NEG[idx] ? -longint'(q) : longint'(q);
  endfunction

endpackage

// ===== rtl/s2l_front.sv =====
// Input clamp, threshold test and linear segment (two pipeline stages).
module s2l_front #(
  parameter int FRAC_BITS      = 16,
  parameter int COEF_FRAC_BITS = 24,
  parameter int ACC_W          = 27,
  parameter logic signed [63:0] COEF0 = 64'sd0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FRAC_BITS:0]      x_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRAC_BITS:0]      x_out,
  output logic                    seg_out,
  output logic [FRAC_BITS:0]      lin_out,
  output logic signed [ACC_W-1:0] acc_out
);
  import s2l_pkg::*;

  localparam int VW     = FRAC_BITS + 1;
  localparam int LIN_PW = FRAC_BITS + 1 + COEF_FRAC_BITS;
  localparam logic [VW-1:0] ONE_X = VW'(64'd1 << FRAC_BITS);
  localparam logic [VW-1:0] THRESH_X =
    VW'(((THRESH_NUM << FRAC_BITS) + THRESH_DEN - 64'd1) / THRESH_DEN);
  localparam logic [COEF_FRAC_BITS-1:0] RECIP =
    COEF_FRAC_BITS'(((RECIP_NUM << COEF_FRAC_BITS) + RECIP_DEN / 2) / RECIP_DEN);
  localparam logic [LIN_PW-1:0] LIN_HALF = LIN_PW'(64'd1 << (COEF_FRAC_BITS - 1));

  logic          va;
  logic [VW-1:0] xa;
  logic          sega;
  logic          ready_a;
  logic          ready_b;
  logic [VW-1:0] x_clamped;
  logic [LIN_PW-1:0] lin_prod;

  assign x_clamped = (x_in > ONE_X) ? ONE_X : x_in;
  assign ready_b   = !out_valid || out_ready;
  assign ready_a   = !va || ready_b;
  assign in_ready  = ready_a;
  assign lin_prod  = LIN_PW'(xa) * LIN_PW'(RECIP) + LIN_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ready_a) begin
      va <= in_valid;
    end
    if (in_valid && ready_a) begin
      xa   <= x_clamped;
      sega <= x_clamped < THRESH_X;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_b) begin
      out_valid <= va;
    end
    if (va && ready_b) begin
      x_out   <= xa;
      seg_out <= sega;
      lin_out <= VW'(lin_prod >> COEF_FRAC_BITS);
      acc_out <= ACC_W'(COEF0);
    end
  end

endmodule

// ===== rtl/s2l_horner_step.sv =====
// One Horner step of the polynomial: acc = round(acc * x) + coefficient.
module s2l_horner_step #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_W     = 27,
  parameter logic signed [63:0] COEF = 64'sd0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FRAC_BITS:0]      x_in,
  input  logic                    seg_in,
  input  logic [FRAC_BITS:0]      lin_in,
  input  logic signed [ACC_W-1:0] acc_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRAC_BITS:0]      x_out,
  output logic                    seg_out,
  output logic [FRAC_BITS:0]      lin_out,
  output logic signed [ACC_W-1:0] acc_out
);

  localparam int PROD_W = ACC_W + FRAC_BITS + 2;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] COEF_A = ACC_W'(COEF);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] shifted;
  logic signed [ACC_W-1:0]  acc_next;

  assign in_ready = !out_valid || out_ready;
  assign prod     = acc_in * $signed({1'b0, x_in});
  assign rnd      = prod + HALF;
  assign shifted  = rnd >>> FRAC_BITS;
  assign acc_next = $signed(shifted[ACC_W-1:0]) + COEF_A;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      x_out   <= x_in;
      seg_out <= seg_in;
      lin_out <= lin_in;
      acc_out <= acc_next;
    end
  end

endmodule

// ===== rtl/s2l_back.sv =====
// Final rescale of the polynomial, segment select and output clamp.
module s2l_back #(
  parameter int FRAC_BITS      = 16,
  parameter int COEF_FRAC_BITS = 24,
  parameter int ACC_W          = 27
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    seg_in,
  input  logic [FRAC_BITS:0]      lin_in,
  input  logic signed [ACC_W-1:0] acc_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRAC_BITS:0]      result
);

  localparam int VW     = FRAC_BITS + 1;
  localparam int D_DOWN = (COEF_FRAC_BITS > FRAC_BITS) ? COEF_FRAC_BITS - FRAC_BITS : 0;
  localparam int D_UP   = (FRAC_BITS > COEF_FRAC_BITS) ? FRAC_BITS - COEF_FRAC_BITS : 0;
  localparam int R_W    = ACC_W + D_UP + 1;
  localparam logic signed [R_W-1:0] HALF  = R_W'((64'd1 << D_DOWN) >> 1);
  localparam logic signed [R_W-1:0] ONE_R = R_W'(64'd1 << FRAC_BITS);
  localparam logic [VW-1:0]         ONE_X = VW'(64'd1 << FRAC_BITS);

  logic signed [R_W-1:0] acc_ext;
  logic signed [R_W-1:0] r;
  logic [VW-1:0]         poly_val;

  assign in_ready = !out_valid || out_ready;
  assign acc_ext  = R_W'(acc_in);
  assign r        = ((acc_ext + HALF) >>> D_DOWN) <<< D_UP;

  always_comb begin
    if (r < 0) begin
      poly_val = '0;
    end else if (r > ONE_R) begin
      poly_val = ONE_X;
    end else begin
      poly_val = VW'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      result <= seg_in ? lin_in : poly_val;
    end
  end

endmodule

// ===== rtl/srgb_to_linear_poly.sv =====
// sRGB to linear-light converter, degree-6 polynomial, nine-stage pipeline.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   input    | in_valid / in_stall  | encoded_value [FRAC_BITS:0]
//   output   | out_valid / out_stall| linear_value  [FRAC_BITS:0]
//
// Stages in order: clamp and threshold, linear multiply, six Horner
// steps (one multiplier each), final rescale and clamp.
// One transaction per cycle sustained while out_stall is low; each stage holds its own valid bit.
// Reset clears the valid bits only.
// out_stall holds the output; upstream stages keep filling empty slots, so
// in_stall rises only once all nine stages are full.
module srgb_to_linear_poly #(
  parameter int FRAC_BITS      = 16,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FRAC_BITS:0]   encoded_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FRAC_BITS:0]   linear_value
);
  import s2l_pkg::*;

  localparam int ACC_W = COEF_FRAC_BITS + 3;
  localparam int VW    = FRAC_BITS + 1;
  localparam int NSTEP = COEF_NUM - 1;

  logic                    v   [NSTEP+1];
  logic                    rdy [NSTEP+1];
  logic [VW-1:0]           xv  [NSTEP+1];
  logic                    seg [NSTEP+1];
  logic [VW-1:0]           lin [NSTEP+1];
  logic signed [ACC_W-1:0] acc [NSTEP+1];
  logic                    front_ready;
  logic                    back_ready;

  assign in_stall = !front_ready;

  s2l_front #(
    .FRAC_BITS      (FRAC_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_W          (ACC_W),
    .COEF0          (64'(coef_q(0, COEF_FRAC_BITS)))
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .x_in      (encoded_value),
    .out_valid (v[0]),
    .out_ready (rdy[0]),
    .x_out     (xv[0]),
    .seg_out   (seg[0]),
    .lin_out   (lin[0]),
    .acc_out   (acc[0])
  );

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    s2l_horner_step #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_W     (ACC_W),
      .COEF      (64'(coef_q(i + 1, COEF_FRAC_BITS)))
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_ready  (rdy[i]),
      .x_in      (xv[i]),
      .seg_in    (seg[i]),
      .lin_in    (lin[i]),
      .acc_in    (acc[i]),
      .out_valid (v[i+1]),
      .out_ready (rdy[i+1]),
      .x_out     (xv[i+1]),
      .seg_out   (seg[i+1]),
      .lin_out   (lin[i+1]),
      .acc_out   (acc[i+1])
    );
  end

  assign rdy[NSTEP] = back_ready;

  s2l_back #(
    .FRAC_BITS      (FRAC_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .ACC_W          (ACC_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[NSTEP]),
    .in_ready  (back_ready),
    .seg_in    (seg[NSTEP]),
    .lin_in    (lin[NSTEP]),
    .acc_in    (acc[NSTEP]),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .result    (linear_value)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && v[0] && v[NSTEP]))
    else $error("input stalled with a free pipeline slot");

  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (linear_value <= VW'(64'd1 << FRAC_BITS)))
    else $error("result above one");

  a_first_stage_source: assert property (@(posedge clk) disable iff (rst)
    $rose(v[0]) |-> $past(front_ready))
    else $error("front stage loaded while not ready");

endmodule

// ===== tb/tb_srgb_to_linear_poly.sv =====
// Testbench for srgb_to_linear_poly: directed and random sRGB codes checked against a predictor.
`timescale 1ns / 100ps

module tb_srgb_to_linear_poly;

  localparam int FRAC_BITS      = 16;
  localparam int COEF_FRAC_BITS = 24;
  localparam int VAL_W          = FRAC_BITS + 1;
  localparam longint UNITY      = longint'(1) <<< FRAC_BITS;
  localparam longint INV_GAMMA_SLOPE =
    ((longint'(100) <<< COEF_FRAC_BITS) + 646) / 1292;
  // Last code on the straight segment: x * 100000 < 4045 * 2^FRAC_BITS
  localparam int KNEE_CODE      = 2650;
  localparam int MAX_CODE       = (1 << (FRAC_BITS + 1)) - 1;
  localparam int PIPE_DEPTH     = 9;
  localparam int HANG_LIMIT     = 2000;

  typedef struct {
    logic [FRAC_BITS:0] encoded;
    logic [FRAC_BITS:0] linear;
  } conversion_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [FRAC_BITS:0] encoded_value = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [FRAC_BITS:0] linear_value;

  conversion_t pending_linear[$];
  longint      horner_coef[7];
  int          mismatch_count = 0;
  int          hang_cycles    = 0;
  int          stall_left     = 0;
  bit          idle_enable    = 1'b1;

  srgb_to_linear_poly #(
    .FRAC_BITS     (FRAC_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .encoded_value(encoded_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .linear_value (linear_value)
  );

  always #5 clk = ~clk;

  // mantissa scaled by 1e-8, rounded half up into COEF_FRAC_BITS fraction bits
  function automatic longint fixed_coef(input longint mant, input bit neg);
    longint q;
    q = ((mant <<< COEF_FRAC_BITS) + 50000000) / 100000000;
    return neg ? -q : q;
  endfunction

  // floor(v / 2^s + 1/2)
  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [FRAC_BITS:0] srgb_decode(input logic [FRAC_BITS:0] enc);
    longint x;
    longint acc;
    longint r;
    x = longint'(enc);
    if (x > UNITY) x = UNITY;
    if (x * 100000 < (longint'(4045) <<< FRAC_BITS)) begin
      r = (x * INV_GAMMA_SLOPE + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    end else begin
      acc = horner_coef[0];
      for (int i = 1; i < 7; i++)
        acc = round_shr(acc * x, FRAC_BITS) + horner_coef[i];
      r = round_shr(acc, COEF_FRAC_BITS - FRAC_BITS);
    end
    if (r < 0) r = 0;
    if (r > UNITY) r = UNITY;
    return r[FRAC_BITS:0];
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FRAC_BITS:0] pick_encoded();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return VAL_W'($urandom_range(0, 3000));
    if (r < 8) return VAL_W'($urandom_range(0, 32'(UNITY)));
    return VAL_W'($urandom_range(0, MAX_CODE));
  endfunction

  // sink back-pressure: runs of stall and no stall
  always @(posedge clk) begin
    if (!idle_enable) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= idle_len();
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // result checker; sampled mid-cycle, transaction completes at next rising edge
  always @(negedge clk) begin
    conversion_t exp_conv;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_linear.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, linear_value);
        mismatch_count++;
      end else begin
        exp_conv = pending_linear.pop_front();
        if (linear_value !== exp_conv.linear) begin
          $display("%0t: linear_value mismatch for code %0d: expected %0d, actual %0d",
                   $time, exp_conv.encoded, exp_conv.linear, linear_value);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
      hang_cycles = 0;
    else
      hang_cycles++;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_linear.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_encoded(input logic [FRAC_BITS:0] enc);
    bit taken;
    int gap;
    conversion_t c;
    in_valid      <= 1'b1;
    encoded_value <= enc;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    c.encoded = enc;
    c.linear  = srgb_decode(enc);
    pending_linear.push_back(c);
    gap = idle_enable ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_linear.size() != 0);
  endtask

  task automatic test_directed_codes();
    int codes[$];
    codes = '{0, 1, 2, KNEE_CODE - 1, KNEE_CODE, KNEE_CODE + 1, KNEE_CODE + 2,
              3000, 16384, 32768, 49152, 65535, 65536, 65537, 100000,
              MAX_CODE, 'h0AAAA, 'h15555, 'h1FFFE};
    foreach (codes[i]) send_encoded(VAL_W'(codes[i]));
  endtask

  task automatic test_linear_segment();
    repeat (80) send_encoded(VAL_W'($urandom_range(0, KNEE_CODE)));
    // transition band around the knee
    repeat (20) send_encoded(VAL_W'($urandom_range(KNEE_CODE - 8, KNEE_CODE + 8)));
  endtask

  task automatic test_back_to_back();
    wait_drained();
    idle_enable = 1'b0;
    repeat (120) send_encoded(pick_encoded());
    idle_enable = 1'b1;
  endtask

  task automatic test_random_mix();
    repeat (200) send_encoded(pick_encoded());
    wait_drained();
    repeat (200) send_encoded(pick_encoded());
  endtask

  initial begin
    horner_coef[0] = fixed_coef(4895813, 1'b1);
    horner_coef[1] = fixed_coef(20727534, 1'b0);
    horner_coef[2] = fixed_coef(40904131, 1'b1);
    horner_coef[3] = fixed_coef(70083753, 1'b0);
    horner_coef[4] = fixed_coef(51648981, 1'b0);
    horner_coef[5] = fixed_coef(3244261, 1'b0);
    horner_coef[6] = fixed_coef(94529, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_codes();
    test_linear_segment();
    test_back_to_back();
    test_random_mix();

    wait_drained();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
